### src/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg: shared definitions for the terminal line editor
// Field widths, character codes, command and result codes, and the table
// that expands one queued action into its result beats.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 4;

   localparam int CMD_W = 2;
   localparam int CHAR_W = 8;
   localparam int INDEX_W = 6;
   localparam int KIND_W = 3;

   localparam logic [CHAR_W-1:0] CH_CTRL_C  = 8'h03;
   localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ESC     = 8'h1B;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_UPPER_C = 8'h43;
   localparam logic [CHAR_W-1:0] CH_UPPER_O = 8'h4F;
   localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_DEL     = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

   typedef enum logic [CMD_W-1:0] {
      CMD_CHAR,
      CMD_START,
      CMD_READ,
      CMD_NONE
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO,
      KIND_LINE,
      KIND_CANCEL,
      KIND_COMPLETE,
      KIND_READ
   } kind_type;

   typedef enum logic [1:0] {
      MODE_READING,
      MODE_DONE,
      MODE_CANCEL
   } mode_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_START,
      ESC_SEQ
   } esc_type;

   typedef enum logic [1:0] {
      FS_CLEAR,
      FS_RUN,
      FS_ZERO
   } front_state_type;

   typedef enum logic [2:0] {
      ACT_ECHO,
      ACT_CRLF,
      ACT_LFLINE,
      ACT_CANCEL,
      ACT_ERASE,
      ACT_COMPLETE,
      ACT_READ
   } action_code_type;

   typedef struct packed {
      action_code_type code;
      logic [CHAR_W-1:0] data;
   } action_type;

   typedef struct packed {
      kind_type kind;
      logic [CHAR_W-1:0] data;
      logic last;
   } result_type;

   function automatic result_type action_result(action_type act, logic [1:0] beat);
      result_type res;
      res = '{KIND_ECHO, act.data, 1'b1};
      unique case (act.code)
         ACT_ECHO: begin
            res = '{KIND_ECHO, act.data, 1'b1};
         end
         ACT_CRLF: begin
            unique case (beat)
               2'd0: res = '{KIND_ECHO, CH_CR, 1'b0};
               2'd1: res = '{KIND_ECHO, CH_LF, 1'b0};
               default: res = '{KIND_LINE, CH_NUL, 1'b1};
            endcase
         end
         ACT_LFLINE: begin
            unique case (beat)
               2'd0: res = '{KIND_ECHO, CH_LF, 1'b0};
               default: res = '{KIND_LINE, CH_NUL, 1'b1};
            endcase
         end
         ACT_CANCEL: begin
            unique case (beat)
               2'd0: res = '{KIND_ECHO, CH_CARET, 1'b0};
               2'd1: res = '{KIND_ECHO, CH_UPPER_C, 1'b0};
               default: res = '{KIND_CANCEL, CH_NUL, 1'b1};
            endcase
         end
         ACT_ERASE: begin
            unique case (beat)
               2'd0: res = '{KIND_ECHO, CH_BS, 1'b0};
               2'd1: res = '{KIND_ECHO, CH_SPACE, 1'b0};
               default: res = '{KIND_ECHO, CH_BS, 1'b1};
            endcase
         end
         ACT_COMPLETE: begin
            res = '{KIND_COMPLETE, CH_NUL, 1'b1};
         end
         ACT_READ: begin
            res = '{KIND_READ, act.data, 1'b1};
         end
         default: begin
            res = '{KIND_ECHO, act.data, 1'b1};
         end
      endcase
      return res;
   endfunction

endpackage

### src/tle_if.sv
// ----------------------------------------------------------------------------
// tle_if: request and response channels of the terminal line editor
// Valid and ready handshake with the payload fields of each channel.
// ----------------------------------------------------------------------------
interface tle_req_if;
   logic valid;
   logic ready;
   logic [tle_pkg::CMD_W-1:0] command;
   logic [tle_pkg::CHAR_W-1:0] char_in;
   logic [tle_pkg::INDEX_W-1:0] read_index;

   modport source (output valid, output command, output char_in, output read_index,
                   input ready);
   modport sink (input valid, input command, input char_in, input read_index,
                 output ready);
endinterface

interface tle_rsp_if;
   logic valid;
   logic ready;
   logic [tle_pkg::KIND_W-1:0] out_kind;
   logic [tle_pkg::CHAR_W-1:0] out_byte;
   logic last;

   modport source (output valid, output out_kind, output out_byte, output last,
                   input ready);
   modport sink (input valid, input out_kind, input out_byte, input last,
                 output ready);
endinterface

### src/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front: request intake and line store
// Accepts requests, updates the line store, write position, escape phase and
// mode, and hands one action per result-producing request to the queue.
// ----------------------------------------------------------------------------
module tle_front #(
   parameter int BUFFER_DEPTH = tle_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tle_req_if.sink req_chan,
   output logic push_valid,
   output tle_pkg::action_type push_data,
   input  logic push_ready
);
   import tle_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

   logic [CHAR_W-1:0] store_mem [BUFFER_DEPTH];

   front_state_type state_ff, state_in;
   logic [AW-1:0] write_pos_ff, write_pos_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;
   esc_type esc_ff, esc_in;
   mode_type mode_ff, mode_in;
   logic s1_valid_ff, s1_valid_in;
   action_code_type s1_act_ff, s1_act_in;
   logic [CHAR_W-1:0] s1_byte_ff, s1_byte_in;
   logic s1_read_ff, s1_read_in;
   logic s1_range_ff, s1_range_in;
   logic [CHAR_W-1:0] rd_ff;

   logic accept;
   logic has_res;
   logic rd_en;
   logic we;
   logic [AW-1:0] waddr;
   logic [CHAR_W-1:0] wdata;
   logic [AW-1:0] pos_inc;
   logic [IW-1:0] idx_ext;
   logic idx_in_range;
   command_type cmd;
   logic [CHAR_W-1:0] ch;

   assign cmd = command_type'(req_chan.command);
   assign ch = req_chan.char_in;
   assign req_chan.ready = (state_ff == FS_RUN) && (!s1_valid_ff || push_ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign pos_inc = (write_pos_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : write_pos_ff + 1'b1;
   assign idx_ext = IW'(req_chan.read_index);
   assign idx_in_range = idx_ext < IW'(BUFFER_DEPTH);

   always_comb begin
      state_in = state_ff;
      write_pos_in = write_pos_ff;
      clear_addr_in = clear_addr_ff;
      esc_in = esc_ff;
      mode_in = mode_ff;
      we = 1'b0;
      waddr = write_pos_ff;
      wdata = CH_NUL;
      has_res = 1'b0;
      rd_en = 1'b0;
      s1_act_in = ACT_ECHO;
      unique case (state_ff)
         FS_CLEAR: begin
            we = 1'b1;
            waddr = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == AW'(BUFFER_DEPTH - 1)) begin
               state_in = FS_RUN;
            end
         end
         FS_RUN: begin
            if (accept) begin
               unique case (cmd)
                  CMD_CHAR: begin
                     if (mode_ff == MODE_READING) begin
                        unique case (ch)
                           CH_CTRL_C: begin
                              has_res = 1'b1;
                              s1_act_in = ACT_CANCEL;
                              mode_in = MODE_CANCEL;
                           end
                           CH_BS, CH_DEL: begin
                              if (write_pos_ff != '0) begin
                                 write_pos_in = write_pos_ff - 1'b1;
                                 we = 1'b1;
                                 waddr = write_pos_ff - 1'b1;
                                 has_res = 1'b1;
                                 s1_act_in = ACT_ERASE;
                              end
                           end
                           CH_TAB: begin
                              has_res = 1'b1;
                              s1_act_in = ACT_COMPLETE;
                           end
                           CH_ESC: begin
                              esc_in = ESC_START;
                           end
                           default: begin
                              unique case (esc_ff)
                                 ESC_NONE: begin
                                    we = 1'b1;
                                    waddr = write_pos_ff;
                                    wdata = ch;
                                    write_pos_in = pos_inc;
                                    state_in = FS_ZERO;
                                    has_res = 1'b1;
                                    if (ch == CH_CR) begin
                                       s1_act_in = ACT_CRLF;
                                       mode_in = MODE_DONE;
                                    end else if (ch == CH_LF) begin
                                       s1_act_in = ACT_LFLINE;
                                       mode_in = MODE_DONE;
                                    end else begin
                                       s1_act_in = ACT_ECHO;
                                    end
                                 end
                                 ESC_START: begin
                                    esc_in = (ch == CH_LBRACK || ch == CH_UPPER_O) ?
                                             ESC_SEQ : ESC_NONE;
                                 end
                                 default: begin
                                    esc_in = ESC_NONE;
                                 end
                              endcase
                           end
                        endcase
                     end
                  end
                  CMD_START: begin
                     write_pos_in = '0;
                     we = 1'b1;
                     waddr = '0;
                     mode_in = MODE_READING;
                     esc_in = ESC_NONE;
                  end
                  CMD_READ: begin
                     has_res = 1'b1;
                     rd_en = 1'b1;
                     s1_act_in = ACT_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FS_ZERO: begin
            we = 1'b1;
            waddr = write_pos_ff;
            state_in = FS_RUN;
         end
         default: begin
            state_in = FS_CLEAR;
         end
      endcase
   end

   assign s1_valid_in = accept ? has_res : (s1_valid_ff && !push_ready);
   assign s1_byte_in = ch;
   assign s1_read_in = rd_en;
   assign s1_range_in = idx_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_CLEAR;
         clear_addr_ff <= '0;
         write_pos_ff <= '0;
         esc_ff <= ESC_NONE;
         mode_ff <= MODE_READING;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_addr_ff <= clear_addr_in;
         write_pos_ff <= write_pos_in;
         esc_ff <= esc_in;
         mode_ff <= mode_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_res) begin
         s1_act_ff <= s1_act_in;
         s1_byte_ff <= s1_byte_in;
         s1_read_ff <= s1_read_in;
         s1_range_ff <= s1_range_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= store_mem[idx_ext[AW-1:0]];
      end
   end

   assign push_valid = s1_valid_ff;
   assign push_data.code = s1_act_ff;
   assign push_data.data = s1_read_ff ? (s1_range_ff ? rd_ff : CH_NUL) : s1_byte_ff;

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, write_pos_ff} < (AW + 1)'(BUFFER_DEPTH))
      else $error("write position beyond the line store");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_CLEAR) |-> !req_chan.ready)
      else $error("request taken during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_ZERO) |=> (state_ff == FS_RUN))
      else $error("terminator write did not return to run");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !push_ready) |=> (s1_valid_ff && $stable(s1_act_ff)))
      else $error("pending action lost while the queue was full");

endmodule

### src/tle_queue.sv
// ----------------------------------------------------------------------------
// tle_queue: action queue between front and back
// A small register queue that lets intake and result delivery stall apart.
// ----------------------------------------------------------------------------
module tle_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  tle_pkg::action_type push_data,
   output logic push_ready,
   output logic pop_valid,
   output tle_pkg::action_type pop_data,
   input  logic pop
);
   import tle_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   action_type entry_mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0] count_ff, count_in;
   logic push_fire;
   logic pop_fire;

   assign push_ready = count_ff != (PW + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = entry_mem[rd_ptr_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PW + 1)'(push_fire) - (PW + 1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_mem[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW + 1)'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      (pop_fire && !push_fire) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count missed a pop");

endmodule

### src/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back: result sequencer
// Expands the action at the queue head into one to three response beats and
// holds each in an output register until it is taken.
// ----------------------------------------------------------------------------
module tle_back (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   input  tle_pkg::action_type pop_data,
   output logic pop,
   tle_rsp_if.source rsp_chan
);
   import tle_pkg::*;

   logic [1:0] beat_ff, beat_in;
   logic out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type res;
   logic load;

   assign res = action_result(pop_data, beat_ff);
   assign load = pop_valid && (!out_valid_ff || rsp_chan.ready);
   assign pop = load && res.last;

   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in = res.last ? 2'd0 : beat_ff + 1'b1;
      end
      out_valid_in = load || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_res_ff <= res;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_kind = out_res_ff.kind;
   assign rsp_chan.out_byte = out_res_ff.data;
   assign rsp_chan.last = out_res_ff.last;

   assert property (@(posedge clock) disable iff (reset)
      (beat_ff != 2'd0) |-> pop_valid)
      else $error("action left the queue before its last beat");

   assert property (@(posedge clock) disable iff (reset)
      beat_ff != 2'd3)
      else $error("beat count beyond three results");

   assert property (@(posedge clock) disable iff (reset)
      (load && !res.last) |=> (beat_ff == $past(beat_ff) + 1'b1))
      else $error("beat count did not advance");

endmodule

### src/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor: terminal line-input front end
// An action passes the front's action register and the queue, and responses
// leave from the output register. Throughput: one request a cycle while the
// queue has room; a stored character stalls the next request, as the line
// store's single write port then writes the terminator. Responses leave at one
// a cycle while the receiver is ready. Reset: the line store is cleared, ready held low.
// ----------------------------------------------------------------------------
module terminal_line_editor #(
   parameter int BUFFER_DEPTH = tle_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tle_req_if.sink req_chan,
   tle_rsp_if.source rsp_chan
);
   import tle_pkg::*;

   logic push_valid;
   logic push_ready;
   action_type push_data;
   logic pop_valid;
   logic pop;
   action_type pop_data;

   tle_front #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .push_valid(push_valid),
      .push_data(push_data),
      .push_ready(push_ready)
   );

   tle_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data(push_data),
      .push_ready(push_ready),
      .pop_valid(pop_valid),
      .pop_data(pop_data),
      .pop(pop)
   );

   tle_back u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_data(pop_data),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

endmodule
